>>> rtl/array_list_insert_remove_search_top_assert.svh
// Assertion macros for the array list block.
// Included by alis_seq, the RTL module that carries concurrent checks; depends on clk and rst_n.
`ifndef ARRAY_LIST_INSERT_REMOVE_SEARCH_TOP_ASSERT_SVH
`define ARRAY_LIST_INSERT_REMOVE_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTH
`define ALIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALIS_ASSERT(lbl, prop, msg)
`define ALIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/alis_pkg.sv
// Package for the array list block: beat types, operation and status codes.
// No dependencies; used by every RTL module of the block.
package alis_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } status_e;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [POS_W-1:0]        found_position;
        logic signed [KEY_W-1:0] removed_key;
        logic [POS_W-1:0]        entry_count;
    } rsp_t;

endpackage

>>> rtl/alis_mem.sv
// Key storage: one write port, one read port with registered read data.
// Depends on alis_pkg for the key width.
module alis_mem #(
    parameter int DEPTH = alis_pkg::CAPACITY_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic signed [alis_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]                    raddr,
    output logic signed [alis_pkg::KEY_W-1:0] rdata
);

    logic signed [alis_pkg::KEY_W-1:0] ram [DEPTH];
    logic signed [alis_pkg::KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        rdata_reg <= ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/alis_seq.sv
// Sequencer for the array list: holds the count, walks the key memory one entry
// per cycle through a single read port and compare. Depends on alis_pkg.
`include "array_list_insert_remove_search_top_assert.svh"

module alis_seq #(
    parameter int CAPACITY = alis_pkg::CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  alis_pkg::req_t                    req,
    input  logic                              out_free,
    output logic                              done,
    output alis_pkg::rsp_t                    result,
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_waddr,
    output logic signed [alis_pkg::KEY_W-1:0] mem_wdata,
    output logic [AW-1:0]                     mem_raddr,
    input  logic signed [alis_pkg::KEY_W-1:0] mem_rdata
);

    localparam int PW = (CW > alis_pkg::POS_W) ? CW : alis_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SRCH = 4'b0010,
        S_REM  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic                              pend_reg, pend_next;
    logic                              first_reg, first_next;
    logic signed [alis_pkg::KEY_W-1:0] key_reg, key_next;
    alis_pkg::rsp_t                    res_reg, res_next;

    logic          pos_ok;
    logic          hit;
    logic [CW-1:0] idx_m2;

    assign pos_ok = (req.position != '0) && (PW'(req.position) <= PW'(count_reg));
    assign hit    = (mem_rdata == key_reg);
    assign idx_m2 = idx_reg - CW'(2);

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        result             = res_reg;
        result.entry_count = alis_pkg::POS_W'(count_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = req.key;
        mem_raddr  = idx_reg[AW-1:0];
        done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next   = req.key;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    first_next = 1'b1;
                    res_next.status         = alis_pkg::ST_OK;
                    res_next.found_position = '0;
                    res_next.removed_key    = '0;
                    res_next.entry_count    = '0;
                    state_next = S_DONE;
                    case (alis_pkg::kind_e'(req.kind))
                        alis_pkg::KIND_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next.status = alis_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        alis_pkg::KIND_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                idx_next   = CW'(PW'(req.position) - PW'(1));
                                state_next = S_REM;
                            end
                            else
                            begin
                                res_next.status = alis_pkg::ST_BADPOS;
                            end
                        end
                        alis_pkg::KIND_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (pend_reg && hit)
                begin
                    res_next.found_position = alis_pkg::POS_W'(idx_reg);
                    state_next = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end
            S_REM:
            begin
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        res_next.removed_key = mem_rdata;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_m2[AW-1:0];
                        mem_wdata = mem_rdata;
                    end
                end
                if (pend_reg && (idx_reg == count_reg))
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
    end

    `ALIS_ASSERT(a_count_bound, (count_reg <= CW'(CAPACITY)), "count above capacity")
    `ALIS_ASSERT(a_srch_idx, (state_reg == S_SRCH) |-> (idx_reg <= count_reg), "search index past count")
    `ALIS_ASSERT(a_rem_dec, ((state_reg == S_REM) && (state_next == S_DONE)) |=> (count_reg == ($past(count_reg) - CW'(1))), "remove did not drop count by one")
    `ALIS_ASSERT(a_ins_inc, (req_valid && req_ready && (req.kind == alis_pkg::KIND_INSERT) && (count_reg < CW'(CAPACITY))) |=> (count_reg == ($past(count_reg) + CW'(1))), "insert did not raise count by one")

endmodule

>>> rtl/array_list_insert_remove_search_top.sv
// Bounded list of signed 32-bit keys: insert at tail, remove by 1-based position with
// compaction, search for first match. Takes one request at a time. Insert, failed requests
// and the unused kind go straight to the done state and enter the output register once it
// is free; search and remove first run a scan loop that reads one key memory entry per
// cycle. The response register lets a new request enter while the last response waits.
// Depends on alis_pkg, alis_seq and alis_mem.
module array_list_insert_remove_search_top #(
    parameter int CAPACITY = alis_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  alis_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output alis_pkg::rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                              rsp_valid_reg;
    alis_pkg::rsp_t                    rsp_reg;
    logic                              out_free;
    logic                              done;
    alis_pkg::rsp_t                    result;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [alis_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [alis_pkg::KEY_W-1:0] mem_rdata;

    assign out_free = !rsp_valid_reg || rsp_ready;

    alis_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    alis_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> verif/tb_array_list_insert_remove_search_top.sv
// Testbench for array_list_insert_remove_search_top: directed and random request beats
// checked field by field against a behavioral list model. Depends on alis_pkg and the RTL.
`timescale 1ns / 1ps

module tb_array_list_insert_remove_search_top;
    import alis_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [CAP-1:0][KEY_W-1:0] keys;
        logic [POS_W-1:0]          count;
    } list_t;

    typedef struct packed {
        req_t r;
        logic hold;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    pending_t req_pending_q[$];
    rsp_t     expected_rsp_q[$];
    list_t    list_model = '0;
    list_t    gen_list = '0;
    int       errors = 0;
    bit       req_beat = 1'b0;
    int       gap_left = 0;
    int       burst_left = 0;
    int       stall_mode = 0;
    int       stall_left = 0;

    array_list_insert_remove_search_top #(.CAPACITY(CAP)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic rsp_t list_apply(input list_t cur, input req_t r, output list_t nxt);
        rsp_t o;
        nxt = cur;
        o = '0;
        case (r.kind)
            KIND_INSERT:
            begin
                if (cur.count >= CAP)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    nxt.keys[cur.count] = r.key;
                    nxt.count = cur.count + 5'd1;
                end
            end
            KIND_REMOVE:
            begin
                if (r.position == 0 || r.position > cur.count)
                begin
                    o.status = ST_BADPOS;
                end
                else
                begin
                    o.removed_key = cur.keys[r.position - 5'd1];
                    for (int i = r.position; i < cur.count; i++)
                        nxt.keys[i - 1] = cur.keys[i];
                    nxt.count = cur.count - 5'd1;
                end
            end
            KIND_SEARCH:
            begin
                for (int i = 0; i < cur.count; i++)
                begin
                    if (o.found_position == 0 && cur.keys[i] == r.key)
                        o.found_position = POS_W'(i + 1);
                end
            end
            default:
            begin
            end
        endcase
        o.entry_count = nxt.count;
        return o;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic signed [KEY_W-1:0] key,
                             input logic [POS_W-1:0] pos, input logic hold);
        pending_t p;
        list_t    after;
        rsp_t     unused;
        p.r.kind = kind;
        p.r.key = key;
        p.r.position = pos;
        p.hold = hold;
        req_pending_q.push_back(p);
        unused = list_apply(gen_list, p.r, after);
        gen_list = after;
    endtask

    function automatic logic signed [KEY_W-1:0] pool_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return 32'sd42;
        endcase
    endfunction

    // driver: bursts with random gaps, holds a marked beat until the pipe is empty
    always @(negedge clk)
    begin : drive
        pending_t nxt;
        if (rst_n && (!req_valid || req_beat))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (req_pending_q.size() == 0 ||
                     (req_pending_q[0].hold && expected_rsp_q.size() != 0))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                nxt = req_pending_q.pop_front();
                req <= nxt.r;
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
        endcase
    end

    always @(posedge clk)
    begin : watch
        rsp_t  want;
        list_t after;
        req_beat = 1'b0;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                req_beat = 1'b1;
                expected_rsp_q.push_back(list_apply(list_model, req, after));
                list_model = after;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report($sformatf("response beat with none expected: %h", rsp));
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("status got %0d want %0d",
                                         rsp.status, want.status));
                    if (rsp.found_position !== want.found_position)
                        report($sformatf("found_position got %0d want %0d",
                                         rsp.found_position, want.found_position));
                    if (rsp.removed_key !== want.removed_key)
                        report($sformatf("removed_key got %0d want %0d",
                                         rsp.removed_key, want.removed_key));
                    if (rsp.entry_count !== want.entry_count)
                        report($sformatf("entry_count got %0d want %0d",
                                         rsp.entry_count, want.entry_count));
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int ins_pct;
        int roll;
        logic [POS_W-1:0] pos;
        logic signed [KEY_W-1:0] k;

        // directed: empty list, extremes, duplicates, bad positions, full list
        queue_req(KIND_SEARCH, 32'sd0, 5'd0, 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd1, 1'b0);
        queue_req(KIND_INSERT, 32'sh8000_0000, 5'd0, 1'b0);
        queue_req(KIND_INSERT, 32'sh7fff_ffff, 5'd31, 1'b0);
        queue_req(KIND_INSERT, 32'sd0, 5'd0, 1'b0);
        queue_req(KIND_INSERT, -32'sd1, 5'd0, 1'b0);
        queue_req(KIND_INSERT, 32'sh7fff_ffff, 5'd0, 1'b0);
        queue_req(KIND_SEARCH, 32'sh7fff_ffff, 5'd31, 1'b0);
        queue_req(KIND_SEARCH, -32'sd1, 5'd0, 1'b0);
        queue_req(KIND_SEARCH, 32'sd12345, 5'd0, 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd0, 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd6, 1'b0);
        queue_req(KIND_REMOVE, -32'sd1, 5'd31, 1'b0);
        queue_req(KIND_UNUSED, $urandom, POS_W'($urandom_range(0, 31)), 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd2, 1'b0);
        queue_req(KIND_SEARCH, 32'sh7fff_ffff, 5'd0, 1'b0);
        queue_req(KIND_INSERT, $urandom, 5'd0, 1'b1);
        while (gen_list.count < CAP)
            queue_req(KIND_INSERT, $urandom, POS_W'($urandom_range(0, 31)), 1'b0);
        queue_req(KIND_INSERT, 32'sd7, 5'd0, 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd16, 1'b0);
        queue_req(KIND_REMOVE, 32'sd0, 5'd1, 1'b0);

        // random phases with drifting insert bias so the list fills and drains
        for (int ph = 0; ph < PHASES; ph++)
        begin
            ins_pct = (ph % 4 == 0) ? 85 : (ph % 4 == 2) ? 15 : $urandom_range(30, 70);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                begin
                    k = ($urandom_range(0, 1) == 0) ? pool_key() : $urandom;
                    queue_req(KIND_INSERT, k, POS_W'($urandom_range(0, 31)),
                              (n == 0 && ph % 3 == 1));
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    queue_req(KIND_UNUSED, $urandom, POS_W'($urandom_range(0, 31)), 1'b0);
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    if (gen_list.count != 0 && $urandom_range(0, 4) != 0)
                        pos = POS_W'($urandom_range(1, gen_list.count));
                    else
                        pos = POS_W'($urandom_range(0, 31));
                    queue_req(KIND_REMOVE, $urandom, pos, 1'b0);
                end
                else
                begin
                    roll = $urandom_range(0, 9);
                    if (gen_list.count != 0 && roll < 6)
                        k = gen_list.keys[$urandom_range(0, gen_list.count - 1)];
                    else if (roll < 8)
                        k = pool_key();
                    else
                        k = $urandom;
                    queue_req(KIND_SEARCH, k, POS_W'($urandom_range(0, 31)), 1'b0);
                end
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
